/* rtl/hv_pkg.sv */
`timescale 1ns / 1ps
// Package for the host name syntax checker.
// Holds the byte word type and ASCII character codes; no dependencies.
package hv_pkg;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } hv_byte_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

endpackage

/* rtl/hv_core.sv */
`timescale 1ns / 1ps
// Per-name state of the host name checker: counters, label flags and the verdict.
// Depends on hv_pkg.
module hv_core #(
  parameter int MAX_NAME_LEN  = 253,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  hv_pkg::hv_byte_t word,
  output logic            name_valid
);
  import hv_pkg::*;

  localparam int NW = $clog2(MAX_NAME_LEN + 2);
  localparam int LW = $clog2(MAX_LABEL_LEN + 2);

  logic [NW-1:0] name_len_r, name_len_nxt;
  logic [LW-1:0] label_len_r, label_len_nxt;
  logic [1:0]    label_cnt_r, label_cnt_nxt;
  logic          hyph_r, hyph_nxt;
  logic          digits_r, digits_nxt;
  logic          long_r, long_nxt;
  logic          fail_r, fail_nxt;

  logic c_dot, c_hyph, c_digit, c_letter;

  always_comb begin
    c_dot    = word.char_byte == CH_DOT;
    c_hyph   = word.char_byte == CH_HYPHEN;
    c_digit  = is_digit(word.char_byte);
    c_letter = is_letter(word.char_byte);

    name_len_nxt  = name_len_r;
    label_len_nxt = label_len_r;
    label_cnt_nxt = label_cnt_r;
    hyph_nxt      = hyph_r;
    digits_nxt    = digits_r;
    long_nxt      = long_r;
    fail_nxt      = fail_r;

    if (name_len_r <= NW'(MAX_NAME_LEN)) begin
      name_len_nxt = name_len_r + NW'(1);
    end

    if (c_dot && !word.last_byte) begin
      if ((label_len_r == '0) || hyph_r) fail_nxt = 1'b1;
      if (label_len_r > LW'(MAX_LABEL_LEN)) long_nxt = 1'b1;
      if (label_cnt_r < 2'd2) label_cnt_nxt = label_cnt_r + 2'd1;
      label_len_nxt = '0;
      hyph_nxt      = 1'b0;
      digits_nxt    = 1'b1;
    end else if (!c_dot) begin
      if (c_hyph) begin
        if ((label_len_r == '0) || hyph_r) fail_nxt = 1'b1;
        hyph_nxt   = 1'b1;
        digits_nxt = 1'b0;
      end else if (c_digit || c_letter) begin
        hyph_nxt = 1'b0;
        if (c_letter) digits_nxt = 1'b0;
      end else begin
        fail_nxt   = 1'b1;
        hyph_nxt   = 1'b0;
        digits_nxt = 1'b0;
      end
      if (label_len_r <= LW'(MAX_LABEL_LEN)) label_len_nxt = label_len_r + LW'(1);
    end

    name_valid = !fail_nxt && (label_len_nxt != '0) && !hyph_nxt && !digits_nxt
              && (name_len_nxt <= NW'(MAX_NAME_LEN))
              && !((label_cnt_nxt != 2'd0)
                   && (long_nxt || (label_len_nxt > LW'(MAX_LABEL_LEN))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && word.last_byte)) begin
      name_len_r  <= '0;
      label_len_r <= '0;
      label_cnt_r <= 2'd0;
      hyph_r      <= 1'b0;
      digits_r    <= 1'b1;
      long_r      <= 1'b0;
      fail_r      <= 1'b0;
    end else if (step) begin
      name_len_r  <= name_len_nxt;
      label_len_r <= label_len_nxt;
      label_cnt_r <= label_cnt_nxt;
      hyph_r      <= hyph_nxt;
      digits_r    <= digits_nxt;
      long_r      <= long_nxt;
      fail_r      <= fail_nxt;
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    label_cnt_r != 2'd3) else $error("label count past saturation");

  a_label_sat: assert property (@(posedge clk) disable iff (!rst_n)
    label_len_r <= LW'(MAX_LABEL_LEN + 1)) else $error("label length past saturation");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && word.last_byte |=> name_len_r == '0 && label_cnt_r == 2'd0 && !fail_r)
    else $error("state not cleared after final byte");

endmodule

/* rtl/hostname_validator_top.sv */
`timescale 1ns / 1ps
// Host name syntax checker: one byte per cycle in unless stalled, one verdict per name out.
// A final byte sits in the input register while a verdict waits, then loads the result register.
// Throughput: one byte per cycle unless stalled, set by the input and result registers.
// Reset: rst_n synchronous active low clears both valid flags and all per-name state.
// Depends on hv_pkg and hv_core.
module hostname_validator_top #(
  parameter int MAX_NAME_LEN  = 253,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] name_valid, [7:1] zero
);
  import hv_pkg::*;

  logic     in_vld_r;
  hv_byte_t in_word_r;
  logic     out_vld_r;
  logic     out_bit_r;
  logic     slot_free;
  logic     step;
  logic     verdict;

  assign slot_free = !out_vld_r || out_tready;
  assign step      = in_vld_r && (!in_word_r.last_byte || slot_free);
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_word_r.char_byte <= in_tdata;
      in_word_r.last_byte <= in_tlast;
    end
  end

  hv_core #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .MAX_LABEL_LEN(MAX_LABEL_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (in_word_r),
    .name_valid(verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && in_word_r.last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_word_r.last_byte) begin
      out_bit_r <= verdict;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_bit_r};

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(step && in_word_r.last_byte))
    else $error("result without a final byte");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_word_r.last_byte |-> !out_vld_r || out_tready)
    else $error("result register overwritten");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step |=> in_vld_r && $stable(in_word_r))
    else $error("stalled byte lost");

endmodule

/* tb/hostname_validator_checker.sv */
`timescale 1ns / 1ps
// Checker for the host name syntax checker: watches both stream channels,
// predicts the verdict of every name and compares each result word.
// Depends on hv_pkg; drives nothing on the block.
module hostname_validator_checker #(
  parameter int MAX_NAME_LEN  = 253,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // last_byte
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [0] name_valid, [7:1] zero
  output int         fail_count,
  output int         outstanding
);
  import hv_pkg::*;

  int unsigned name_len;
  int unsigned label_len;
  int unsigned label_cnt;
  bit          hyphen_last;
  bit          digits_only;
  bit          long_label;
  bit          syntax_bad;
  bit          verdict_q[$];
  int          errors = 0;

  assign fail_count = errors;

  task automatic open_label();
    label_len   = 0;
    hyphen_last = 1'b0;
    digits_only = 1'b1;
  endtask

  task automatic clear_name();
    name_len   = 0;
    label_cnt  = 0;
    long_label = 1'b0;
    syntax_bad = 1'b0;
    open_label();
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("%0t hostname check mismatch, %s: got %h want %h", $time, what, got, want);
  endtask

  task automatic absorb_byte(input logic [7:0] c, input logic last);
    bit is_num;
    bit is_alpha;
    bit ok;
    is_num   = (c >= CH_0) && (c <= CH_9);
    is_alpha = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    if (name_len <= MAX_NAME_LEN) name_len++;
    if (c == CH_DOT && !last) begin
      if (label_len == 0 || hyphen_last) syntax_bad = 1'b1;
      if (label_len > MAX_LABEL_LEN) long_label = 1'b1;
      if (label_cnt < 2) label_cnt++;
      open_label();
    end else begin
      if (c != CH_DOT) begin
        if (c == CH_HYPHEN) begin
          if (label_len == 0 || hyphen_last) syntax_bad = 1'b1;
          hyphen_last = 1'b1;
          digits_only = 1'b0;
        end else if (is_num || is_alpha) begin
          hyphen_last = 1'b0;
          if (is_alpha) digits_only = 1'b0;
        end else begin
          syntax_bad  = 1'b1;
          hyphen_last = 1'b0;
          digits_only = 1'b0;
        end
        if (label_len <= MAX_LABEL_LEN) label_len++;
      end
      if (last) begin
        ok = !syntax_bad && label_len > 0 && !hyphen_last && !digits_only &&
             name_len <= MAX_NAME_LEN &&
             !(label_cnt > 0 && (long_label || label_len > MAX_LABEL_LEN));
        verdict_q.push_back(ok);
        clear_name();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_name();
      verdict_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("word with no name pending", out_tdata, 8'h00);
        end else begin
          if (out_tdata[0] != verdict_q[0])
            report_mismatch("name_valid", out_tdata, {7'b0, verdict_q[0]});
          if (out_tdata[7:1] != 7'b0)
            report_mismatch("padding", out_tdata, {7'b0, verdict_q[0]});
          void'(verdict_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
    end
    outstanding <= verdict_q.size();
  end

endmodule

/* tb/hostname_validator_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the host name syntax checker: sends directed and random
// names with random gaps and stalls, and gives the verdict.
// Depends on hv_pkg, hostname_validator_top and hostname_validator_checker.
module hostname_validator_top_tb;
  import hv_pkg::*;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire  [7:0] out_tdata;
  int         fail_count;
  int         outstanding;

  logic [7:0] name_buf[$];
  int         bytes_sent  = 0;
  bit         src_calm    = 1'b0;
  bit         sink_calm   = 1'b0;
  bit         drain_phase = 1'b0;
  int         stall_left  = 0;

  hostname_validator_top #(
    .MAX_NAME_LEN (253),
    .MAX_LABEL_LEN(63)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  hostname_validator_checker #(
    .MAX_NAME_LEN (253),
    .MAX_LABEL_LEN(63)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (drain_phase || sink_calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) sink_calm <= !sink_calm;
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    if (!drain_phase && !src_calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_name();
    foreach (name_buf[i]) send_word(name_buf[i], i == name_buf.size() - 1);
    if ($urandom_range(0, 7) == 0) src_calm = !src_calm;
  endtask

  // hold the sender until every verdict is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic add_label(input int len, input bit numeric);
    bit hy = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (!numeric && !hy && i > 0 && i < len - 1 && $urandom_range(0, 5) == 0) begin
        name_buf.push_back(CH_HYPHEN);
        hy = 1'b1;
      end else begin
        hy = 1'b0;
        case ($urandom_range(0, numeric ? 0 : 2))
          0:       name_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
          1:       name_buf.push_back(8'(CH_UP_A + $urandom_range(0, 25)));
          default: name_buf.push_back(8'(CH_LO_A + $urandom_range(0, 25)));
        endcase
      end
    end
  endtask

  task automatic make_random_name();
    int kind;
    int nl;
    int len;
    int total;
    kind = $urandom_range(0, 9);
    name_buf.delete();
    if (kind <= 6) begin
      nl = $urandom_range(1, 4);
      for (int k = 0; k < nl; k++) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
        add_label(len, $urandom_range(0, 5) == 0);
        if (k < nl - 1) name_buf.push_back(CH_DOT);
      end
      if ($urandom_range(0, 3) == 0) name_buf.push_back(CH_DOT);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0:       name_buf[$urandom_range(0, name_buf.size() - 1)] = CH_HYPHEN;
          1:       name_buf[$urandom_range(0, name_buf.size() - 1)] = CH_DOT;
          default: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
        endcase
      end
    end else if (kind <= 8) begin
      len = $urandom_range(1, 20);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 3))
          0:       name_buf.push_back(8'($urandom_range(0, 255)));
          1:       name_buf.push_back(CH_DOT);
          2:       name_buf.push_back(CH_HYPHEN);
          default: add_label(1, 1'b0);
        endcase
      end
    end else begin
      total = $urandom_range(248, 258);
      if ($urandom_range(0, 2) == 0) begin
        add_label(total, 1'b0);
      end else begin
        while (name_buf.size() + 66 < total) begin
          add_label($urandom_range(61, 65), 1'b0);
          name_buf.push_back(CH_DOT);
        end
        add_label(total - name_buf.size(), 1'b0);
      end
      if ($urandom_range(0, 1) == 0) name_buf.push_back(CH_DOT);
    end
  endtask

  initial begin
    string directed[] = '{".", "a", "9", "-", "a.", "a..b", "z-", "a--b", "1.x", "x.5"};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[j]) begin
      name_buf.delete();
      for (int i = 0; i < directed[j].len(); i++) name_buf.push_back(directed[j][i]);
      send_name();
    end
    name_buf = '{8'h00};
    send_name();
    name_buf = '{8'hFF};
    send_name();
    drain_results();

    while (bytes_sent < 1700) begin
      if (bytes_sent > 1450) drain_phase <= 1'b1;
      make_random_name();
      send_name();
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("[hostname_validator_top] OK");
    else
      $display("[hostname_validator_top] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[hostname_validator_top] ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/hv_pkg.sv
rtl/hv_core.sv
rtl/hostname_validator_top.sv
tb/hostname_validator_checker.sv
tb/hostname_validator_top_tb.sv
